[rtl/ddnc_pkg.sv]
// ----------------------------------------------------------------------------
// ddnc_pkg
// Types and constants shared by the date / day-count converter.
// ----------------------------------------------------------------------------
package ddnc_pkg;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_YEAR  = 2'd1,
    ST_MONTH = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic        valid;
    logic [19:0] count;
    logic [11:0] year;
    logic [8:0]  doy;
    status_t     status;
  } result_t;

  localparam logic [11:0] FIRST_YEAR  = 12'd1973;
  localparam logic [20:0] EPOCH_COUNT = 21'd720624;
  localparam logic [20:0] LEAPS_1972  = 21'd478;
  // Day 1 of year 1 is count 367, since year 0 is counted as a leap year.
  localparam logic [19:0] YEAR1_BASE  = 20'd367;
  localparam logic [19:0] DAYS_400    = 20'd146097;
  localparam logic [17:0] DAYS_100    = 18'd36524;
  localparam logic [10:0] DAYS_4      = 11'd1461;
  localparam logic [10:0] DAYS_1      = 11'd365;
  // Reciprocals: x*5243>>19 is x/100 and x*5243>>21 is x/400 for 12-bit x;
  // x*45934>>26 is x/1461 for x below 36525.
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam logic [15:0] RECIP_1461  = 16'd45934;

  function automatic logic [8:0] days_before(input logic [3:0] month);
    logic [8:0] d;
    case (month)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

[rtl/ddnc_fwd.sv]
// ----------------------------------------------------------------------------
// ddnc_fwd
// Date to day count: three compute stages, then three delay stages so the
// latency matches the reverse path.
// ----------------------------------------------------------------------------
module ddnc_fwd #(
  parameter int YEAR_SPAN = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_in,
  input  logic [11:0]       year_in,
  input  logic [3:0]        month_in,
  input  logic [4:0]        day_in,
  output ddnc_pkg::result_t res_out
);
  import ddnc_pkg::*;

  localparam logic [11:0] LAST_YEAR = 12'(1972 + YEAR_SPAN);

  // Stage 1
  logic        v1_r, err_yr1_r, err_mo1_r;
  logic [11:0] year1_r;
  logic [3:0]  month1_r;
  logic [4:0]  day1_r;
  logic [24:0] py1_r, pn1_r;
  // Stage 2
  logic        v2_r, err_yr2_r, err_mo2_r;
  logic [11:0] year2_r;
  logic [8:0]  doy2_r;
  logic [9:0]  lc2_r;
  logic [19:0] k365_2_r;
  // Stage 3 and delay line
  result_t     res3_r;
  result_t     dly_r [3];

  logic [11:0] n1;
  logic [11:0] n1b;
  logic [5:0]  qy100, qn100;
  logic [3:0]  qy400, qn400;
  logic        leap;
  logic [10:0] k;
  logic [8:0]  doy_nxt;
  logic [20:0] total;
  result_t     res3_nxt;

  assign n1 = year_in - 12'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= valid_in;
    end
    err_yr1_r <= (year_in < FIRST_YEAR) || (year_in > LAST_YEAR);
    err_mo1_r <= (month_in == 4'd0) || (month_in > 4'd12);
    year1_r   <= year_in;
    month1_r  <= month_in;
    day1_r    <= day_in;
    py1_r     <= 25'(year_in * RECIP_100);
    pn1_r     <= 25'(n1 * RECIP_100);
  end

  always_comb begin
    qy100 = py1_r[24:19];
    qy400 = py1_r[24:21];
    qn100 = pn1_r[24:19];
    qn400 = pn1_r[24:21];
    n1b   = year1_r - 12'd1;
    leap  = (year1_r[1:0] == 2'b00) &&
            ((13'(year1_r) != 13'(qy100 * 7'd100)) ||
             (13'(year1_r) == 13'(qy400 * 9'd400)));
    doy_nxt = days_before(month1_r) + 9'(day1_r) +
              9'(leap && (month1_r > 4'd2));
    k = 11'(year1_r - FIRST_YEAR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    err_yr2_r <= err_yr1_r;
    err_mo2_r <= err_mo1_r;
    year2_r   <= year1_r;
    doy2_r    <= doy_nxt;
    // Leap years in 1..year-1.
    lc2_r     <= 10'(n1b[11:2]) - 10'(qn100) + 10'(qn400);
    k365_2_r  <= 20'(k * DAYS_1);
  end

  always_comb begin
    total = EPOCH_COUNT + 21'(k365_2_r) + 21'(lc2_r) - LEAPS_1972 + 21'(doy2_r);
    res3_nxt = '0;
    res3_nxt.valid = v2_r;
    if (err_yr2_r) begin
      res3_nxt.status = ST_YEAR;
    end else if (err_mo2_r) begin
      res3_nxt.status = ST_MONTH;
    end else if (total[20]) begin
      res3_nxt.status = ST_RANGE;
    end else begin
      res3_nxt.status = ST_OK;
      res3_nxt.count  = total[19:0];
      res3_nxt.year   = year2_r;
      res3_nxt.doy    = doy2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res3_r.valid <= 1'b0;
      for (int i = 0; i < 3; i++) dly_r[i].valid <= 1'b0;
    end else begin
      res3_r   <= res3_nxt;
      dly_r[0] <= res3_r;
      dly_r[1] <= dly_r[0];
      dly_r[2] <= dly_r[1];
    end
  end

  assign res_out = dly_r[2];

endmodule

[rtl/ddnc_rev.sv]
// ----------------------------------------------------------------------------
// ddnc_rev
// Day count to year and day of year: the count is split into 400-, 100-,
// 4- and 1-year periods, each period size in a stage of its own.
// ----------------------------------------------------------------------------
module ddnc_rev #(
  parameter int YEAR_SPAN = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_in,
  input  logic [19:0]       count_in,
  output ddnc_pkg::result_t res_out
);
  import ddnc_pkg::*;

  localparam logic [11:0] LAST_YEAR = 12'(1972 + YEAR_SPAN);

  logic [4:0]  v_r;
  logic [4:0]  err_r;
  logic [19:0] cnt_r [5];
  logic [19:0] d1_r;
  logic [2:0]  q400_r [5];
  logic [17:0] r1_r;
  logic [1:0]  q100_r [3];
  logic [15:0] r2_r;
  logic [15:0] r2b_r;
  logic [31:0] p4_r;
  logic [4:0]  q4_r;
  logic [10:0] r3_r;
  result_t     res_r;

  logic [2:0]  q400_nxt;
  logic [1:0]  q100_nxt, q1;
  logic [17:0] r2_full;
  logic [4:0]  q4;
  logic [11:0] year_nxt;
  logic [8:0]  doy_nxt;
  result_t     res_nxt;

  always_comb begin
    q400_nxt = '0;
    for (int i = 1; i < 8; i++) begin
      q400_nxt = q400_nxt + 3'((count_in - YEAR1_BASE) >= 20'(i * DAYS_400));
    end
    q100_nxt = '0;
    for (int i = 1; i < 4; i++) begin
      q100_nxt = q100_nxt + 2'(r1_r >= 18'(i * DAYS_100));
    end
    r2_full = r1_r - 18'(q100_nxt * DAYS_100);
    q4 = p4_r[30:26];
    q1 = 2'(r3_r >= DAYS_1) + 2'(r3_r >= 11'(2 * DAYS_1)) + 2'(r3_r >= 11'(3 * DAYS_1));
    doy_nxt  = 9'(r3_r - 11'(q1 * DAYS_1)) + 9'd1;
    year_nxt = 12'd1 + 12'(q400_r[4] * 9'd400) + 12'(q100_r[2] * 7'd100) +
               12'({q4_r, 2'b00}) + 12'(q1);
    res_nxt = '0;
    res_nxt.valid = v_r[4];
    if (err_r[4] || (year_nxt > LAST_YEAR)) begin
      res_nxt.status = ST_RANGE;
    end else begin
      res_nxt.status = ST_OK;
      res_nxt.count  = cnt_r[4];
      res_nxt.year   = year_nxt;
      res_nxt.doy    = doy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
      res_r.valid <= 1'b0;
    end else begin
      v_r   <= {v_r[3:0], valid_in};
      res_r <= res_nxt;
    end
    err_r     <= {err_r[3:0], (count_in <= EPOCH_COUNT[19:0])};
    // Stage 1: days since the first day of year 1 and the 400-year period.
    d1_r      <= count_in - YEAR1_BASE;
    cnt_r[0]  <= count_in;
    q400_r[0] <= q400_nxt;
    // Stage 2: remainder within the 400-year period.
    r1_r      <= 18'(d1_r - 20'(q400_r[0] * DAYS_400));
    // Stage 3: century, capped at three.
    q100_r[0] <= q100_nxt;
    r2_r      <= r2_full[15:0];
    // Stage 4: reciprocal product for the 4-year period.
    p4_r      <= r2_r * RECIP_1461;
    r2b_r     <= r2_r;
    // Stage 5: remainder within the 4-year period.
    q4_r      <= q4;
    r3_r      <= 11'(r2b_r - 16'(q4 * DAYS_4));
    for (int i = 1; i < 5; i++) begin
      cnt_r[i]  <= cnt_r[i-1];
      q400_r[i] <= q400_r[i-1];
    end
    q100_r[1] <= q100_r[0];
    q100_r[2] <= q100_r[1];
  end

  assign res_out = res_r;

endmodule

[rtl/date_day_number_converter.sv]
// ----------------------------------------------------------------------------
// date_day_number_converter
// Gregorian date to day count and day count to year / day of year.
// ----------------------------------------------------------------------------
// The latency from start to out_valid is the same for both directions.
// Throughput: one word per cycle; busy is always low and the pipeline has
// no stall, so the receiver takes each result in the cycle it appears.
// Reset: synchronous, active low; it clears the valid bits of every stage.
module date_day_number_converter #(
  parameter int YEAR_SPAN = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [11:0] in_year_in,
  input  logic [3:0]  in_month_in,
  input  logic [4:0]  in_day_in,
  input  logic [19:0] in_day_count_in,
  output logic        out_valid,
  output logic [19:0] out_day_count_out,
  output logic [11:0] out_year_out,
  output logic [8:0]  out_day_of_year_out,
  output logic [1:0]  out_status
);
  import ddnc_pkg::*;

  result_t fwd_res, rev_res, sel;
  result_t out_r;

  assign busy = 1'b0;

  ddnc_fwd #(.YEAR_SPAN(YEAR_SPAN)) u_fwd (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_in (start && !in_req_type),
    .year_in  (in_year_in),
    .month_in (in_month_in),
    .day_in   (in_day_in),
    .res_out  (fwd_res)
  );

  ddnc_rev #(.YEAR_SPAN(YEAR_SPAN)) u_rev (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_in (start && in_req_type),
    .count_in (in_day_count_in),
    .res_out  (rev_res)
  );

  // Both paths have the same latency, so at most one presents a word.
  assign sel = rev_res.valid ? rev_res : fwd_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_r.valid <= 1'b0;
    end else begin
      out_r <= sel;
    end
  end

  assign out_valid           = out_r.valid;
  assign out_day_count_out   = out_r.count;
  assign out_year_out        = out_r.year;
  assign out_day_of_year_out = out_r.doy;
  assign out_status          = out_r.status;

endmodule

[dv/tb_date_day_number_converter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_date_day_number_converter
// Drives forward and reverse conversion requests through the converter and
// checks every result word against a predictor held in the testbench.
// ----------------------------------------------------------------------------
module tb_date_day_number_converter;
  import ddnc_pkg::*;

  localparam int SPAN = 256;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic        req;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [19:0] count;
  } request_t;

  typedef struct packed {
    logic [19:0] count;
    logic [11:0] year;
    logic [8:0]  doy;
    status_t     status;
  } conversion_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_req_type = 1'b0;
  logic [11:0] in_year_in = '0;
  logic [3:0]  in_month_in = '0;
  logic [4:0]  in_day_in = '0;
  logic [19:0] in_day_count_in = '0;
  logic        out_valid;
  logic [19:0] out_day_count_out;
  logic [11:0] out_year_out;
  logic [8:0]  out_day_of_year_out;
  logic [1:0]  out_status;

  request_t    pending_words[$];
  conversion_t expected_words[$];
  int          error_count = 0;
  int          cycle_count = 0;
  int          gap_left = 0;
  bit          gaps_on = 1'b1;
  bit          hold_for_drain = 1'b0;

  date_day_number_converter #(.YEAR_SPAN(SPAN)) dut (.*);

  always #5 clk = ~clk;

  function automatic bit is_leap(int y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic int month_offset(int m);
    int offsets[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    return offsets[m - 1];
  endfunction

  function automatic conversion_t convert_date(request_t r);
    conversion_t c;
    int doy, total, rem, y, len;
    c = '{count: '0, year: '0, doy: '0, status: ST_OK};
    if (r.req == 1'b0) begin
      if (r.year < 1973 || r.year - 1973 >= SPAN) begin
        c.status = ST_YEAR;
      end else if (r.month < 1 || r.month > 12) begin
        c.status = ST_MONTH;
      end else begin
        doy = month_offset(r.month) + r.day;
        if (r.month > 2 && is_leap(r.year)) doy++;
        total = 720624;
        for (y = 1973; y < r.year; y++) total += is_leap(y) ? 366 : 365;
        total += doy;
        if (total > 20'hFFFFF) c.status = ST_RANGE;
        else begin
          c.count = 20'(total);
          c.year = r.year;
          c.doy = 9'(doy);
        end
      end
    end else begin
      c.status = ST_RANGE;
      if (r.count > 720624) begin
        rem = r.count - 720624;
        for (y = 1973; y < 1973 + SPAN; y++) begin
          len = is_leap(y) ? 366 : 365;
          if (rem <= len) begin
            c.status = ST_OK;
            c.count = r.count;
            c.year = 12'(y);
            c.doy = 9'(rem);
            break;
          end
          rem -= len;
        end
      end
    end
    return c;
  endfunction

  function automatic int count_of_year_end(int y);
    int total;
    total = 720624;
    for (int k = 1973; k <= y; k++) total += is_leap(k) ? 366 : 365;
    return total;
  endfunction

  function automatic request_t random_word();
    request_t r;
    r.req = 1'($urandom_range(0, 1));
    r.year = $urandom_range(0, 9) == 0 ? 12'($urandom()) :
             12'($urandom_range(1973, 1973 + SPAN - 1));
    r.month = $urandom_range(0, 9) == 0 ? 4'($urandom()) : 4'($urandom_range(1, 12));
    r.day = 5'($urandom());
    case ($urandom_range(0, 9))
      0: r.count = 20'($urandom());
      1: r.count = 20'(count_of_year_end($urandom_range(1972, 1973 + SPAN - 1))
                   + $urandom_range(0, 2) - 1);
      default: r.count = 20'($urandom_range(720625,
                                            count_of_year_end(1973 + SPAN - 1) + 10));
    endcase
    return r;
  endfunction

  // Driver: new words change at the falling edge; gaps come in bursts.
  always @(negedge clk) begin
    if (rst_n && start && !busy) begin
      pending_words.pop_front();
      expected_words.push_back(convert_date({in_req_type, in_year_in, in_month_in,
                                             in_day_in, in_day_count_in}));
    end
    if (gap_left > 0) gap_left--;
    else if (gaps_on && $urandom_range(0, 15) == 0) gap_left = $urandom_range(1, 16);
    if (rst_n && pending_words.size() > 0 && gap_left == 0 &&
        !(hold_for_drain && expected_words.size() > 0)) begin
      start <= 1'b1;
      {in_req_type, in_year_in, in_month_in, in_day_in, in_day_count_in} <= pending_words[0];
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: results are taken at the rising edge that ends their cycle.
  always @(posedge clk) begin
    conversion_t exp_c;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word count=%0d year=%0d doy=%0d status=%0d",
                 $realtime, out_day_count_out, out_year_out, out_day_of_year_out,
                 out_status);
        error_count++;
      end else begin
        exp_c = expected_words.pop_front();
        if (out_day_count_out !== exp_c.count) begin
          $display("%0t: day count expected %0d actual %0d", $realtime, exp_c.count,
                   out_day_count_out);
          error_count++;
        end
        if (out_year_out !== exp_c.year) begin
          $display("%0t: year expected %0d actual %0d", $realtime, exp_c.year,
                   out_year_out);
          error_count++;
        end
        if (out_day_of_year_out !== exp_c.doy) begin
          $display("%0t: day of year expected %0d actual %0d", $realtime, exp_c.doy,
                   out_day_of_year_out);
          error_count++;
        end
        if (out_status !== exp_c.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, exp_c.status,
                   out_status);
          error_count++;
        end
      end
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    request_t r;
    // Directed words: span edges, bad months, day zero, leap years, count edges.
    pending_words.push_back('{1'b0, 12'd1973, 4'd1, 5'd0, 20'd0});
    pending_words.push_back('{1'b0, 12'd1973, 4'd1, 5'd1, 20'hFFFFF});
    pending_words.push_back('{1'b0, 12'd1972, 4'd1, 5'd1, 20'd0});
    pending_words.push_back('{1'b0, 12'd0, 4'd0, 5'd31, 20'd0});
    pending_words.push_back('{1'b0, 12'd4095, 4'd15, 5'd31, 20'hFFFFF});
    pending_words.push_back('{1'b0, 12'(1973 + SPAN - 1), 4'd12, 5'd31, 20'd0});
    pending_words.push_back('{1'b0, 12'(1973 + SPAN), 4'd12, 5'd31, 20'd0});
    pending_words.push_back('{1'b0, 12'd1980, 4'd0, 5'd1, 20'd0});
    pending_words.push_back('{1'b0, 12'd1980, 4'd13, 5'd1, 20'd0});
    pending_words.push_back('{1'b0, 12'd1976, 4'd3, 5'd1, 20'd0});
    pending_words.push_back('{1'b0, 12'd2000, 4'd12, 5'd31, 20'd0});
    pending_words.push_back('{1'b0, 12'd2100, 4'd3, 5'd1, 20'd0});
    pending_words.push_back('{1'b1, 12'd0, 4'd0, 5'd0, 20'd0});
    pending_words.push_back('{1'b1, 12'hFFF, 4'hF, 5'h1F, 20'd720624});
    pending_words.push_back('{1'b1, 12'd0, 4'd0, 5'd0, 20'd720625});
    pending_words.push_back('{1'b1, 12'd0, 4'd0, 5'd0, 20'(count_of_year_end(1976))});
    pending_words.push_back('{1'b1, 12'd0, 4'd0, 5'd0,
                              20'(count_of_year_end(1973 + SPAN - 1))});
    pending_words.push_back('{1'b1, 12'd0, 4'd0, 5'd0,
                              20'(count_of_year_end(1973 + SPAN - 1) + 1)});
    pending_words.push_back('{1'b1, 12'd0, 4'd0, 5'd0, 20'hFFFFF});
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_words.size() == 0);
    // Let the pipeline drain completely before each of the first six random words.
    hold_for_drain = 1'b1;
    for (int i = 0; i < 1100; i++) begin
      r = random_word();
      pending_words.push_back(r);
      if (i == 5) begin
        wait (pending_words.size() == 0);
        hold_for_drain = 1'b0;
      end
      if (i == 900) begin
        wait (pending_words.size() == 0);
        gaps_on = 1'b0;
      end
    end
    wait (pending_words.size() == 0 && expected_words.size() == 0);
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
